// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the septet unpacker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on the rising clock edge, skipped while in reset.
`define SPU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SPU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`else

`define SPU_ASSERT(label, prop, msg)
`define SPU_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- design/spu_pkg.sv -----
// ----------------------------------------------------------------------------
// spu_pkg
// Types and constants of the SMS user-data septet unpacker.
// ----------------------------------------------------------------------------
package spu_pkg;

  // Character mapping: above '9' subtract 55, otherwise subtract 48.
  localparam logic [7:0] CHAR_NINE     = 8'd57;
  localparam logic [7:0] ALPHA_OFFSET  = 8'd55;
  localparam logic [7:0] DIGIT_OFFSET  = 8'd48;

  localparam int unsigned SEPTET_BITS  = 7;
  localparam int unsigned OCTET_BITS   = 8;
  localparam int unsigned ACC_BITS     = 2 * SEPTET_BITS;

  // Result queue depth; must hold at least one full two-result push.
  localparam int unsigned QUEUE_DEPTH  = 4;

  typedef struct packed {
    logic [7:0] hex_char;
    logic       message_start;
    logic       binary_mode;
  } spu_in_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       empty_res;
  } spu_out_t;

  // Results produced by one character: 0, 1 or 2 of them, r0 first.
  typedef struct packed {
    logic [1:0] cnt;
    spu_out_t   r0;
    spu_out_t   r1;
  } spu_push_t;

endpackage

// ----- design/spu_core.sv -----
// ----------------------------------------------------------------------------
// spu_core
// Input register, message state and one-pass nibble/septet decode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spu_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spu_pkg::spu_in_t   in_data_i,
  input  logic               room_i,
  output spu_pkg::spu_push_t push_o
);

  localparam int unsigned AccW = spu_pkg::ACC_BITS;

  logic             in_valid_q, in_valid_d;
  spu_pkg::spu_in_t in_data_q;
  logic             accept, fire;

  logic [3:0]      high_q, high_d;
  logic            phase_q, phase_d;
  logic            have_len_q, have_len_d;
  logic            done_q, done_d;
  logic            raw_q, raw_d;
  logic [7:0]      count_q, count_d;
  logic [7:0]      emitted_q, emitted_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [2:0]      held_q, held_d;

  // Working values after a message start has been applied.
  logic [3:0]      high_e;
  logic            phase_e, have_len_e, done_e, raw_e;
  logic [7:0]      count_e, emitted_e;
  logic [AccW-1:0] acc_e, acc_or;
  logic [2:0]      held_e;
  logic [7:0]      diff, octet, em1, em2;
  logic [3:0]      nib, held8;
  logic            d1, second;

  assign fire       = in_valid_q && room_i;
  assign in_stall_o = in_valid_q && !room_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    high_e     = high_q;
    phase_e    = phase_q;
    have_len_e = have_len_q;
    done_e     = done_q;
    raw_e      = raw_q;
    count_e    = count_q;
    emitted_e  = emitted_q;
    acc_e      = acc_q;
    held_e     = held_q;
    if (in_data_q.message_start) begin
      high_e     = '0;
      phase_e    = 1'b0;
      have_len_e = 1'b0;
      done_e     = 1'b0;
      raw_e      = in_data_q.binary_mode;
      count_e    = '0;
      emitted_e  = '0;
      acc_e      = '0;
      held_e     = '0;
    end

    diff   = (in_data_q.hex_char > spu_pkg::CHAR_NINE) ?
             in_data_q.hex_char - spu_pkg::ALPHA_OFFSET :
             in_data_q.hex_char - spu_pkg::DIGIT_OFFSET;
    nib    = diff[3:0];
    octet  = {high_e, nib};
    acc_or = acc_e | (AccW'(octet) << held_e);
    held8  = {1'b0, held_e} + 4'd8;
    em1    = emitted_e + 8'd1;
    em2    = emitted_e + 8'd2;
    d1     = (em1 == count_e);
    second = (held8 >= 4'(2 * spu_pkg::SEPTET_BITS)) && !d1;

    high_d     = high_e;
    phase_d    = phase_e;
    have_len_d = have_len_e;
    done_d     = done_e;
    raw_d      = raw_e;
    count_d    = count_e;
    emitted_d  = emitted_e;
    acc_d      = acc_e;
    held_d     = held_e;
    push_o     = '0;

    if (fire && !done_e) begin
      if (!phase_e) begin
        high_d  = nib;
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        if (!have_len_e) begin
          have_len_d = 1'b1;
          count_d    = octet;
          emitted_d  = '0;
          if (octet == 8'd0) begin
            done_d          = 1'b1;
            push_o.cnt      = 2'd1;
            push_o.r0.code  = '0;
            push_o.r0.last  = 1'b1;
            push_o.r0.empty_res = 1'b1;
          end
        end else if (raw_e) begin
          emitted_d      = em1;
          done_d         = d1;
          push_o.cnt     = 2'd1;
          push_o.r0.code = octet;
          push_o.r0.last = d1;
        end else if (emitted_e != count_e) begin
          // Low septet always completes; a second one when 14 bits are held and the first is not the last.
          push_o.r0.code = {1'b0, acc_or[spu_pkg::SEPTET_BITS-1:0]};
          if (second) begin
            push_o.cnt     = 2'd2;
            push_o.r0.last = 1'b0;
            push_o.r1.code = {1'b0, acc_or[AccW-1:spu_pkg::SEPTET_BITS]};
            push_o.r1.last = (em2 == count_e);
            emitted_d      = em2;
            done_d         = (em2 == count_e);
            acc_d          = '0;
            held_d         = 3'(held8 - 4'(2 * spu_pkg::SEPTET_BITS));
          end else begin
            push_o.cnt     = 2'd1;
            push_o.r0.last = d1;
            emitted_d      = em1;
            done_d         = d1;
            acc_d          = acc_or >> spu_pkg::SEPTET_BITS;
            held_d         = 3'(held8 - 4'(spu_pkg::SEPTET_BITS));
          end
        end
      end
    end else if (fire) begin
      // Idle: only a message start changes state.
      raw_d = raw_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      high_q     <= '0;
      phase_q    <= 1'b0;
      have_len_q <= 1'b0;
      done_q     <= 1'b1;
      raw_q      <= 1'b0;
      count_q    <= '0;
      emitted_q  <= '0;
      acc_q      <= '0;
      held_q     <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (fire) begin
        high_q     <= high_d;
        phase_q    <= phase_d;
        have_len_q <= have_len_d;
        done_q     <= done_d;
        raw_q      <= raw_d;
        count_q    <= count_d;
        emitted_q  <= emitted_d;
        acc_q      <= acc_d;
        held_q     <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= in_data_i;
    end
  end

  `SPU_ASSERT(a_two_not_first_last, (push_o.cnt == 2'd2) |-> !push_o.r0.last,
              "first of two results flagged last")
  `SPU_ASSERT(a_empty_alone, push_o.r0.empty_res |->
              (push_o.cnt == 2'd1 && push_o.r0.last && push_o.r0.code == 8'd0),
              "empty result malformed")
  `SPU_ASSERT(a_last_goes_idle, (push_o.cnt != 2'd0 &&
              (push_o.cnt == 2'd2 ? push_o.r1.last : push_o.r0.last)) |=> done_q,
              "final result did not leave the block idle")

endmodule

// ----- design/spu_outq.sv -----
// ----------------------------------------------------------------------------
// spu_outq
// Result queue: takes up to two results a cycle, hands out one while out_stall_i is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spu_outq #(
  parameter int unsigned Depth = spu_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spu_pkg::spu_push_t push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spu_pkg::spu_out_t  out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  spu_pkg::spu_out_t mem_q [Depth];
  logic [PtrW-1:0]   rd_q, rd_d, wr_q, wr_d, wr_n1, wr_n2;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  // Leave space for a full two-result push.
  assign room_o      = (cnt_q <= CntW'(Depth - 2));

  assign wr_n1 = ptr_inc(wr_q);
  assign wr_n2 = ptr_inc(wr_n1);

  always_comb begin
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    case (push_i.cnt)
      2'd1:    wr_d = wr_n1;
      2'd2:    wr_d = wr_n2;
      default: wr_d = wr_q;
    endcase
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_n1] <= push_i.r1;
    end
  end

  `SPU_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue overfilled")
  `SPU_ASSERT(a_push_has_room, (push_i.cnt != 2'd0) |-> room_o,
              "push into queue without room")
  `SPU_ASSERT(a_cnt_track, 1'b1 |=> (cnt_q == CntW'($past(cnt_q) +
              CntW'($past(push_i.cnt)) - CntW'($past(pop)))),
              "queue fill count out of step")

endmodule

// ----- design/sms_pdu_septet_unpacker_unit.sv -----
// ----------------------------------------------------------------------------
// sms_pdu_septet_unpacker_unit
// SMS user-data hex text in, GSM septets (or raw octets) out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | input     | in_valid_i/in_stall_o   | hex_char, message_start, binary_mode
//  out     | output    | out_valid_o/out_stall_i | code, last, empty_res
//
//  One character per cycle enters while in_stall_o is low; it waits in the input
//  register until the queue has room, and is then decoded into the queue.
//  A character yields up to two results; the queue drains one per cycle while
//  out_stall_i is low; input stalls while fewer than two queue entries are free.
//  Reset leaves the block idle until a character with message_start.
// ----------------------------------------------------------------------------
module sms_pdu_septet_unpacker_unit #(
  parameter int unsigned QueueDepth = spu_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spu_pkg::spu_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spu_pkg::spu_out_t out_data_o
);

  spu_pkg::spu_push_t push;
  logic               room;

  spu_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .room_i     (room),
    .push_o     (push)
  );

  spu_outq #(
    .Depth (QueueDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- dv/septet_unpack_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// septet_unpack_checker
// Watches both channels of the septet unpacker. It decodes every accepted
// character into the codes it should release and compares each released
// transaction with the oldest waiting code.
// ----------------------------------------------------------------------------
module septet_unpack_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  spu_pkg::spu_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  spu_pkg::spu_out_t out_data_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  // Decoder state, a mirror of what the block holds.
  logic [3:0]  hi_nib      = '0;
  logic        low_phase   = 1'b0;
  logic        len_known   = 1'b0;
  logic        msg_idle    = 1'b1;
  logic        octet_mode  = 1'b0;
  logic [7:0]  elem_total  = '0;
  logic [7:0]  elem_sent   = '0;
  logic [13:0] septet_acc  = '0;
  logic [3:0]  acc_bits    = '0;

  spu_pkg::spu_out_t expected_codes[$];
  int unsigned       fail_count = 0;

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  task automatic decode_char(input spu_pkg::spu_in_t item);
    logic [7:0]        mapped;
    logic [7:0]        octet;
    logic [15:0]       shifted;
    int unsigned       produced;
    spu_pkg::spu_out_t res;
    produced = 0;
    if (item.message_start) begin
      hi_nib     = '0;
      low_phase  = 1'b0;
      len_known  = 1'b0;
      msg_idle   = 1'b0;
      octet_mode = item.binary_mode;
      elem_total = '0;
      elem_sent  = '0;
      septet_acc = '0;
      acc_bits   = '0;
    end
    if (msg_idle) return;

    // Any character is mapped, wrapping at eight bits.
    mapped = (item.hex_char > spu_pkg::CHAR_NINE) ?
             item.hex_char - spu_pkg::ALPHA_OFFSET :
             item.hex_char - spu_pkg::DIGIT_OFFSET;
    if (!low_phase) begin
      hi_nib    = mapped[3:0];
      low_phase = 1'b1;
      return;
    end
    low_phase = 1'b0;
    octet     = {hi_nib, mapped[3:0]};

    if (!len_known) begin
      len_known  = 1'b1;
      elem_total = octet;
      elem_sent  = '0;
      if (octet == 8'd0) begin
        msg_idle      = 1'b1;
        res.code      = 8'd0;
        res.last      = 1'b1;
        res.empty_res = 1'b1;
        expected_codes.push_back(res);
      end
      return;
    end

    if (octet_mode) begin
      elem_sent = elem_sent + 8'd1;
      if (elem_sent == elem_total) msg_idle = 1'b1;
      res.code      = octet;
      res.last      = msg_idle;
      res.empty_res = 1'b0;
      expected_codes.push_back(res);
      return;
    end

    // Append the octet above the bits still held, LSB first.
    shifted    = 16'(octet) << acc_bits[2:0];
    septet_acc = septet_acc | shifted[13:0];
    acc_bits   = acc_bits + 4'd8;
    while (acc_bits >= spu_pkg::SEPTET_BITS && elem_sent != elem_total &&
           produced < 2) begin
      res.code      = {1'b0, septet_acc[6:0]};
      septet_acc    = septet_acc >> spu_pkg::SEPTET_BITS;
      acc_bits      = acc_bits - 4'(spu_pkg::SEPTET_BITS);
      elem_sent     = elem_sent + 8'd1;
      if (elem_sent == elem_total) msg_idle = 1'b1;
      res.last      = msg_idle;
      res.empty_res = 1'b0;
      expected_codes.push_back(res);
      produced++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spu_pkg::spu_out_t want;
    if (!rst_ni) begin
      hi_nib     = '0;
      low_phase  = 1'b0;
      len_known  = 1'b0;
      msg_idle   = 1'b1;
      octet_mode = 1'b0;
      elem_total = '0;
      elem_sent  = '0;
      septet_acc = '0;
      acc_bits   = '0;
      expected_codes.delete();
      pending_o <= 0;
    end else begin
      // Compare before decoding: a character never yields a result in its own cycle.
      if (out_valid_i && !out_stall_i) begin
        if (expected_codes.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("[%0t] unexpected transaction: code %0d last %0b empty_res %0b",
                     $time, out_data_i.code, out_data_i.last, out_data_i.empty_res);
        end else begin
          want = expected_codes.pop_front();
          if (out_data_i.code !== want.code || out_data_i.last !== want.last ||
              out_data_i.empty_res !== want.empty_res) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"[%0t] mismatch: expected code %0d last %0b empty_res %0b,",
                        " got code %0d last %0b empty_res %0b"},
                       $time, want.code, want.last, want.empty_res,
                       out_data_i.code, out_data_i.last, out_data_i.empty_res);
          end
        end
      end
      if (in_valid_i && !in_stall_i) decode_char(in_data_i);
      pending_o <= expected_codes.size();
    end
    mismatch_count_o <= fail_count;
  end

endmodule

// ----- dv/sms_pdu_septet_unpacker_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sms_pdu_septet_unpacker_unit_tb
// Feeds hex-text messages in text and binary mode, with broken messages,
// stray characters and random idling on both channels; a checker beside the
// block predicts every code and reports the failure count for the verdict.
// ----------------------------------------------------------------------------
module sms_pdu_septet_unpacker_unit_tb;

  localparam int unsigned CHAR_TARGET  = 1350;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  spu_pkg::spu_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  spu_pkg::spu_out_t out_data;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned chars_sent         = 0;
  int unsigned quiet_cycles       = 0;
  int unsigned mismatches;
  int unsigned codes_pending;

  always #6 clk_i = ~clk_i;

  sms_pdu_septet_unpacker_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  septet_unpack_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .pending_o        (codes_pending)
  );

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // End the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** sms_pdu_septet_unpacker_unit: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? spu_pkg::DIGIT_OFFSET + 8'(nib)
                         : spu_pkg::ALPHA_OFFSET + 8'(nib);
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic start, input logic bin);
    spu_pkg::spu_in_t item;
    item.hex_char      = ch;
    item.message_start = start;
    item.binary_mode   = bin;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic send_octet(input logic [7:0] octet, input logic start, input logic bin);
    send_char(hex_digit(octet[7:4]), start, bin);
    send_char(hex_digit(octet[3:0]), 1'b0, 1'($urandom_range(1)));
  endtask

  // Send length octet and data; sometimes cut short, corrupt characters,
  // or trail stray characters that the idle block drops.
  task automatic send_message(input logic [7:0] count, input logic bin);
    int unsigned octets;
    int unsigned total;
    int unsigned cut;
    logic [7:0]  octet;
    logic [7:0]  ch;
    octets = bin ? count : (7 * count + 7) / 8;
    total  = 2 + 2 * octets;
    cut    = ($urandom_range(99) < 10) ? $urandom_range(1, total - 1) : total;
    octet  = count;
    for (int unsigned i = 0; i < cut; i++) begin
      if (i >= 2 && i % 2 == 0) octet = 8'($urandom_range(255));
      ch = hex_digit((i % 2 == 0) ? octet[7:4] : octet[3:0]);
      if ($urandom_range(99) < 8) ch = 8'($urandom_range(255));
      send_char(ch, i == 0, (i == 0) ? bin : 1'($urandom_range(1)));
      chars_sent++;
    end
    if (cut == total && $urandom_range(99) < 15)
      repeat ($urandom_range(1, 3))
        send_char(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
  endtask

  initial begin
    int unsigned roll;
    logic [7:0]  count;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero count in both modes.
    send_octet(8'h00, 1'b1, 1'b0);
    send_octet(8'h00, 1'b1, 1'b1);
    // Binary, one octet built from non-hex characters.
    send_octet(8'h01, 1'b1, 1'b1);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b1);
    // Text, eight septets of all ones; the seventh octet completes two.
    send_octet(8'h08, 1'b1, 1'b0);
    repeat (7) send_octet(8'hFF, 1'b0, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
        1: begin sender_idle_pct = 88; receiver_stall_pct <= 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct <= 88; end
        default: begin sender_idle_pct = 34; receiver_stall_pct <= 34; end
      endcase
      while (chars_sent < (phase + 1) * CHAR_TARGET / 4) begin
        roll = $urandom_range(99);
        if (roll < 5)       count = 8'($urandom_range(255));
        else if (roll < 10) count = 8'd0;
        else                count = 8'($urandom_range(1, 20));
        send_message(count, 1'($urandom_range(1)));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (codes_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && codes_pending == 0) begin
      $display("** sms_pdu_septet_unpacker_unit: PASSED **");
    end else begin
      $display("** sms_pdu_septet_unpacker_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sms_pdu_septet_unpacker_unit.f -----
+incdir+design
design/spu_pkg.sv
design/spu_core.sv
design/spu_outq.sv
design/sms_pdu_septet_unpacker_unit.sv
dv/septet_unpack_checker.sv
dv/sms_pdu_septet_unpacker_unit_tb.sv
